// ----- sv/sqtu_pkg.sv -----
// Package for the SARSA Q-table update core: field widths, register codes,
// step numbers and the control program of the sequencer.
// No dependencies.
`default_nettype none

package sqtu_pkg;

  localparam int DEF_STATE_COUNT  = 16;
  localparam int DEF_ACTION_COUNT = 4;

  // field widths
  localparam int S_FIELD_W   = 4;
  localparam int A_FIELD_W   = 2;
  localparam int Q_W         = 32;
  localparam int FRAC_W      = 16;
  localparam int DIFF_W      = Q_W + 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_LEARNING_RATE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DISCOUNT_FACTOR   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXPLORE_THRESHOLD = 2'd2;

  localparam logic [FRAC_W-1:0] RESET_ALPHA   = 16'd6554;
  localparam logic [FRAC_W-1:0] RESET_GAMMA   = 16'd62259;
  localparam logic [FRAC_W-1:0] RESET_EPSILON = 16'd6554;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // program steps
  typedef logic [3:0] step_t;
  localparam step_t STEP_CLEAR     = 4'd0;
  localparam step_t STEP_IDLE      = 4'd1;
  localparam step_t STEP_RD_CUR    = 4'd2;
  localparam step_t STEP_CAP_CUR   = 4'd3;
  localparam step_t STEP_EXP_RD    = 4'd4;
  localparam step_t STEP_EXP_CAP   = 4'd5;
  localparam step_t STEP_SCAN_RD   = 4'd6;
  localparam step_t STEP_SCAN_CMP  = 4'd7;
  localparam step_t STEP_MUL_GAMMA = 4'd8;
  localparam step_t STEP_DIFF      = 4'd9;
  localparam step_t STEP_MUL_ALPHA = 4'd10;
  localparam step_t STEP_RES_UPD   = 4'd11;
  localparam step_t STEP_RES_READ  = 4'd12;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_CUR,
    RD_EXPLORE,
    RD_SCAN
  } rd_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAP_CUR,
    OP_CAP_EXPLORE,
    OP_SCAN,
    OP_MUL_GAMMA,
    OP_DIFF,
    OP_MUL_ALPHA,
    OP_RES_UPDATE,
    OP_RES_READ
  } op_t;

  typedef enum logic [2:0] {
    JMP_NEVER,
    JMP_ALWAYS,
    JMP_NO_INPUT,
    JMP_IS_READ,
    JMP_GREEDY,
    JMP_SCAN_MORE,
    JMP_CLEAR_MORE
  } jmp_t;

  typedef struct packed {
    logic    take_input;
    rd_sel_t rd_sel;
    op_t     op;
    jmp_t    jmp;
    step_t   target;
  } ctrl_word_t;

  // control store: jump to target when the condition holds, else next step
  function automatic ctrl_word_t microcode(step_t step);
    ctrl_word_t cw;
    cw = '{take_input: 1'b0, rd_sel: RD_NONE, op: OP_NONE, jmp: JMP_NEVER,
           target: STEP_IDLE};
    unique case (step)
      STEP_CLEAR: begin
        cw.op     = OP_CLEAR;
        cw.jmp    = JMP_CLEAR_MORE;
        cw.target = STEP_CLEAR;
      end
      STEP_IDLE: begin
        cw.take_input = 1'b1;
        cw.jmp        = JMP_NO_INPUT;
        cw.target     = STEP_IDLE;
      end
      STEP_RD_CUR: begin
        cw.rd_sel = RD_CUR;
        cw.jmp    = JMP_IS_READ;
        cw.target = STEP_RES_READ;
      end
      STEP_CAP_CUR: begin
        cw.op     = OP_CAP_CUR;
        cw.jmp    = JMP_GREEDY;
        cw.target = STEP_SCAN_RD;
      end
      STEP_EXP_RD: begin
        cw.rd_sel = RD_EXPLORE;
      end
      STEP_EXP_CAP: begin
        cw.op     = OP_CAP_EXPLORE;
        cw.jmp    = JMP_ALWAYS;
        cw.target = STEP_MUL_GAMMA;
      end
      STEP_SCAN_RD: begin
        cw.rd_sel = RD_SCAN;
      end
      STEP_SCAN_CMP: begin
        cw.op     = OP_SCAN;
        cw.jmp    = JMP_SCAN_MORE;
        cw.target = STEP_SCAN_RD;
      end
      STEP_MUL_GAMMA: cw.op = OP_MUL_GAMMA;
      STEP_DIFF:      cw.op = OP_DIFF;
      STEP_MUL_ALPHA: cw.op = OP_MUL_ALPHA;
      STEP_RES_UPD: begin
        cw.op     = OP_RES_UPDATE;
        cw.jmp    = JMP_ALWAYS;
        cw.target = STEP_IDLE;
      end
      STEP_RES_READ: begin
        cw.op     = OP_RES_READ;
        cw.jmp    = JMP_ALWAYS;
        cw.target = STEP_IDLE;
      end
      default: begin
        cw.jmp    = JMP_ALWAYS;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sarsa_q_table_update_core.sv -----
// SARSA Q-table update core: Q-table memory, shared datapath and a
// microcoded step sequencer. Depends on sqtu_pkg.
//
// Channel   Dir  Handshake                  Content
// s_axis    in   tvalid/tready              experience or table read request
// m_axis    out  tvalid/tready              updated or read Q entry + flags
// cfg       in   cfg_wr_en, no wait         alpha, gamma, epsilon
//
// Update: when greedy, the argmax scan reads the next state's table row one entry
// at a time through the single memory read port; when exploring, only the next
// state's random-action entry is read. A table read returns the current entry.
// After reset a clearing pass writes STATE_COUNT*ACTION_COUNT zero entries,
// one per cycle, while s_axis_tready stays low; config writes still land.
// A result waits in the output register; the next item may be taken then,
// and the sequencer holds at its result step until that register frees.
`default_nettype none

module sarsa_q_table_update_core #(
  parameter int STATE_COUNT  = sqtu_pkg::DEF_STATE_COUNT,
  parameter int ACTION_COUNT = sqtu_pkg::DEF_ACTION_COUNT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [sqtu_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [sqtu_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // current_state[3:0], action_taken[5:4], reward[37:6],
  // next_state_index[41:38], explore_draw[57:42], random_action[59:58]
  input  wire logic [sqtu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // cmd[0]
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // q_value[31:0], next_action[33:32], explored[34], saturated[35]
  output logic [sqtu_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);
  import sqtu_pkg::*;

  localparam int DEPTH = STATE_COUNT * ACTION_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(STATE_COUNT);
  localparam int ACW   = $clog2(ACTION_COUNT);
  localparam int PAD_W = OUT_TDATA_W - Q_W - A_FIELD_W - 2;

  // index wrap tables
  logic [SW-1:0]  s_wrap [2**S_FIELD_W];
  logic [ACW-1:0] a_wrap [2**A_FIELD_W];

  for (genvar gi = 0; gi < 2**S_FIELD_W; gi++) begin : g_s_wrap
    assign s_wrap[gi] = SW'(gi % STATE_COUNT);
  end
  for (genvar gj = 0; gj < 2**A_FIELD_W; gj++) begin : g_a_wrap
    assign a_wrap[gj] = ACW'(gj % ACTION_COUNT);
  end

  // configuration
  logic [FRAC_W-1:0] learning_rate;
  logic [FRAC_W-1:0] discount_factor;
  logic [FRAC_W-1:0] explore_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate     <= RESET_ALPHA;
      discount_factor   <= RESET_GAMMA;
      explore_threshold <= RESET_EPSILON;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LEARNING_RATE:     learning_rate     <= cfg_data;
        REG_DISCOUNT_FACTOR:   discount_factor   <= cfg_data;
        REG_EXPLORE_THRESHOLD: explore_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  step_t      step;
  step_t      step_next;
  ctrl_word_t cw;
  logic       in_accept;
  logic       load_out;
  logic       advance;
  logic       jump_taken;

  // latched item
  logic                    cmd_q;
  logic [SW-1:0]           s_q;
  logic [ACW-1:0]          a_q;
  logic signed [Q_W-1:0]   r_q;
  logic [SW-1:0]           ns_q;
  logic [FRAC_W-1:0]       draw_q;
  logic [ACW-1:0]          ra_q;

  // datapath
  logic [AW-1:0]             clr_cnt;
  logic [ACW-1:0]            scan_idx;
  logic signed [Q_W-1:0]     cur_q;
  logic signed [Q_W-1:0]     best_q;
  logic [ACW-1:0]            na_q;
  logic                      explored_q;
  logic signed [Q_W-1:0]     g_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [DIFF_W-1:0]  delta_q;

  // output register
  logic                  out_valid;
  logic [Q_W-1:0]        out_q;
  logic [A_FIELD_W-1:0]  out_na;
  logic                  out_expl;
  logic                  out_sat;

  // memory
  logic [Q_W-1:0] mem [DEPTH];
  logic           mem_re;
  logic           mem_we;
  logic [AW-1:0]  mem_raddr;
  logic [AW-1:0]  mem_waddr;
  logic [Q_W-1:0] mem_wdata;
  logic [Q_W-1:0] rdata;

  logic explore;
  logic [AW-1:0] cur_addr;
  logic signed [Q_W+FRAC_W:0]    gamma_prod;
  logic signed [DIFF_W+FRAC_W:0] alpha_prod;
  logic signed [DIFF_W-1:0]      diff_sum;
  logic signed [DIFF_W:0]        upd_sum;
  logic [Q_W-1:0]                upd_val;
  logic                          upd_sat;

  assign cw            = microcode(step);
  assign s_axis_tready = cw.take_input;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign load_out      = (cw.op == OP_RES_UPDATE) || (cw.op == OP_RES_READ);
  assign advance       = !(load_out && out_valid && !m_axis_tready);
  assign explore       = draw_q < explore_threshold;

  always_comb begin
    unique case (cw.jmp)
      JMP_NEVER:      jump_taken = 1'b0;
      JMP_ALWAYS:     jump_taken = 1'b1;
      JMP_NO_INPUT:   jump_taken = !s_axis_tvalid;
      JMP_IS_READ:    jump_taken = cmd_q == CMD_READ;
      JMP_GREEDY:     jump_taken = !explore;
      JMP_SCAN_MORE:  jump_taken = scan_idx != ACW'(ACTION_COUNT - 1);
      JMP_CLEAR_MORE: jump_taken = clr_cnt != AW'(DEPTH - 1);
      default:        jump_taken = 1'b1;
    endcase
  end

  always_comb begin
    if (!advance) begin
      step_next = step;
    end else if (jump_taken) begin
      step_next = cw.target;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_CLEAR;
    end else begin
      step <= step_next;
    end
  end

  // address and arithmetic
  assign cur_addr = AW'(AW'(s_q) * AW'(ACTION_COUNT) + AW'(a_q));

  always_comb begin
    unique case (cw.rd_sel)
      RD_CUR:     mem_raddr = cur_addr;
      RD_EXPLORE: mem_raddr = AW'(AW'(ns_q) * AW'(ACTION_COUNT) + AW'(ra_q));
      RD_SCAN:    mem_raddr = AW'(AW'(ns_q) * AW'(ACTION_COUNT) + AW'(scan_idx));
      default:    mem_raddr = cur_addr;
    endcase
  end

  assign mem_re = cw.rd_sel != RD_NONE;

  // floor rounding falls out of the arithmetic shift of the product
  assign gamma_prod = best_q * $signed({1'b0, discount_factor});
  assign alpha_prod = diff_q * $signed({1'b0, learning_rate});
  assign diff_sum   = DIFF_W'(r_q) + DIFF_W'(g_q) - DIFF_W'(cur_q);
  assign upd_sum    = (DIFF_W+1)'(cur_q) + (DIFF_W+1)'(delta_q);

  always_comb begin
    upd_sat = 1'b1;
    if (!upd_sum[DIFF_W] && (upd_sum[DIFF_W-1:Q_W-1] != '0)) begin
      upd_val = {1'b0, {(Q_W-1){1'b1}}};
    end else if (upd_sum[DIFF_W] && (upd_sum[DIFF_W-1:Q_W-1] != '1)) begin
      upd_val = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      upd_val = upd_sum[Q_W-1:0];
      upd_sat = 1'b0;
    end
  end

  assign mem_we    = (cw.op == OP_CLEAR) || ((cw.op == OP_RES_UPDATE) && advance);
  assign mem_waddr = (cw.op == OP_CLEAR) ? clr_cnt : cur_addr;
  assign mem_wdata = (cw.op == OP_CLEAR) ? '0 : upd_val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q  <= s_axis_tuser;
      s_q    <= s_wrap[s_axis_tdata[3:0]];
      a_q    <= a_wrap[s_axis_tdata[5:4]];
      r_q    <= s_axis_tdata[37:6];
      ns_q   <= s_wrap[s_axis_tdata[41:38]];
      draw_q <= s_axis_tdata[57:42];
      ra_q   <= a_wrap[s_axis_tdata[59:58]];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cw.op == OP_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_CAP_CUR: begin
        cur_q      <= rdata;
        scan_idx   <= '0;
        explored_q <= 1'b0;
      end
      OP_CAP_EXPLORE: begin
        best_q     <= rdata;
        na_q       <= ra_q;
        explored_q <= 1'b1;
      end
      OP_SCAN: begin
        // first entry always taken; later ones only when strictly larger
        if ((scan_idx == '0) || ($signed(rdata) > best_q)) begin
          best_q <= rdata;
          na_q   <= scan_idx;
        end
        scan_idx <= scan_idx + ACW'(1);
      end
      OP_MUL_GAMMA: g_q     <= gamma_prod[Q_W+FRAC_W-1:FRAC_W];
      OP_DIFF:      diff_q  <= diff_sum;
      OP_MUL_ALPHA: delta_q <= alpha_prod[DIFF_W+FRAC_W-1:FRAC_W];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out && advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && advance) begin
      if (cw.op == OP_RES_UPDATE) begin
        out_q    <= upd_val;
        out_na   <= A_FIELD_W'(na_q);
        out_expl <= explored_q;
        out_sat  <= upd_sat;
      end else begin
        out_q    <= rdata;
        out_na   <= '0;
        out_expl <= 1'b0;
        out_sat  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_sat, out_expl, out_na, out_q};

  // checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load_out && advance) |-> !(out_valid && !m_axis_tready))
    else $error("pending result overwritten");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (step == STEP_RD_CUR))
    else $error("accepted transaction did not start the program");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sat) |->
      ((out_q == {1'b0, {(Q_W-1){1'b1}}}) || (out_q == {1'b1, {(Q_W-1){1'b0}}})))
    else $error("saturated flag without clipped value");

  a_read_no_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (step != STEP_CLEAR)) |-> (cmd_q == CMD_UPDATE))
    else $error("table written during a read transaction");

endmodule

`default_nettype wire
